### sv/calmap_pkg.sv
// Shared types, constants and the segment table of the channel index map.
package calmap_pkg;

    // Number of channels in the map; also the index given for a miss.
    localparam int unsigned CHANNELS = 5184;
    localparam logic [12:0] INDEX_MISS = 13'(CHANNELS);

    // Number of contiguous index segments.
    localparam int unsigned NSEG = 14;

    // Operation codes.
    localparam logic OP_TO_INDEX   = 1'b0;
    localparam logic OP_TO_CHANNEL = 1'b1;

    // One segment: a depth, an eta band and the index range that it covers.
    typedef struct packed {
        logic [1:0]        depth;
        logic signed [5:0] lo;
        logic signed [5:0] hi;
        logic              odd_only;
        logic [12:0]       base;
        logic [12:0]       top;
    } t_seg;

    // Class result of a channel.
    typedef struct packed {
        logic sub;
        logic err;
    } t_class;

    // Segments in index order; top is the first index past the segment.
    localparam t_seg SEGS [NSEG] = '{
        '{2'd1, -6'sd29, -6'sd21, 1'b1, 13'd0,    13'd324},
        '{2'd1, -6'sd20, -6'sd1,  1'b0, 13'd324,  13'd1764},
        '{2'd1,  6'sd1,   6'sd20, 1'b0, 13'd1764, 13'd3204},
        '{2'd1,  6'sd21,  6'sd29, 1'b1, 13'd3204, 13'd3528},
        '{2'd2, -6'sd29, -6'sd21, 1'b1, 13'd3528, 13'd3852},
        '{2'd2, -6'sd20, -6'sd18, 1'b0, 13'd3852, 13'd4068},
        '{2'd2, -6'sd16, -6'sd15, 1'b0, 13'd4068, 13'd4212},
        '{2'd2,  6'sd15,  6'sd16, 1'b0, 13'd4212, 13'd4356},
        '{2'd2,  6'sd18,  6'sd20, 1'b0, 13'd4356, 13'd4572},
        '{2'd2,  6'sd21,  6'sd29, 1'b1, 13'd4572, 13'd4896},
        '{2'd3, -6'sd28, -6'sd27, 1'b1, 13'd4896, 13'd4968},
        '{2'd3, -6'sd16, -6'sd16, 1'b0, 13'd4968, 13'd5040},
        '{2'd3,  6'sd16,  6'sd16, 1'b0, 13'd5040, 13'd5112},
        '{2'd3,  6'sd27,  6'sd28, 1'b1, 13'd5112, 13'd5184}
    };

    // Barrel or endcap class, with the out-of-range cases flagged.
    function automatic t_class classify(input logic [1:0] depth,
                                        input logic signed [5:0] eta);
        logic [5:0] a;
        t_class     c;
        a = eta[5] ? 6'(~eta + 6'd1) : eta;
        c.err = (a > 6'd29) || (depth == 2'd0) || (a == 6'd29 && depth > 2'd2);
        if (c.err) begin
            c.sub = 1'b0;
        end else if (a <= 6'd15) begin
            c.sub = 1'b0;
        end else if (a == 6'd16) begin
            c.sub = (depth > 2'd2);
        end else begin
            c.sub = 1'b1;
        end
        return c;
    endfunction

endpackage

### sv/calorimeter_channel_index_map.sv
// Top level of the calorimeter channel index map: triple to index and back.

// The block takes one item in every clock cycle and never raises busy. An
// accepted item is loaded into the input register, the segment lookup and
// index arithmetic run in one combinational pass, and the result register
// then loads the result. o_done is high for exactly the one cycle in which
// the result stands on the outputs; the receiver cannot stall, so it must take
// the result in that cycle. Results come out in the order items went in.
module calorimeter_channel_index_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [1:0]        i_depth_in,
    input  logic signed [5:0] i_eta_in,
    input  logic [6:0]        i_phi_in,
    input  logic [12:0]       i_index_in,
    output logic              o_done,
    output logic [12:0]       o_index_out,
    output logic              o_found,
    output logic [1:0]        o_depth_out,
    output logic signed [5:0] o_eta_out,
    output logic [6:0]        o_phi_out,
    output logic              o_subdetector,
    output logic              o_class_error
);

    // Input register.
    logic              r_in_valid;
    logic              r_operation;
    logic [1:0]        r_depth;
    logic signed [5:0] r_eta;
    logic [6:0]        r_phi;
    logic [12:0]       r_index;

    // Result register.
    logic              r_done;
    logic [12:0]       r_index_out;
    logic              r_found;
    logic [1:0]        r_depth_out;
    logic signed [5:0] r_eta_out;
    logic [6:0]        r_phi_out;
    logic              r_sub;
    logic              r_err;

    logic [12:0]       n_index_out;
    logic              n_found;
    logic [1:0]        n_depth_out;
    logic signed [5:0] n_eta_out;
    logic [6:0]        n_phi_out;
    calmap_pkg::t_class n_class;

    // Forward path signals.
    logic              fwd_hit;
    logic [3:0]        fwd_k;
    calmap_pkg::t_seg  seg_f;
    logic [5:0]        diff_f;
    logic [4:0]        row_f;
    logic [6:0]        pm1_f;
    logic [6:0]        pos_f;
    logic              phi_ok_f;
    logic [12:0]       index_f;

    // Reverse path signals.
    logic              rev_hit;
    logic [3:0]        rev_k;
    calmap_pkg::t_seg  seg_r;
    logic [12:0]       off_r;
    logic [8:0]        q_r;
    logic [14:0]       prod_r;
    logic [4:0]        row_r;
    logic [12:0]       rowper_r;
    logic [6:0]        pos_r;
    logic [6:0]        phi_r;
    logic signed [5:0] eta_r;

    // Row number times channels per row (36 or 72) by shift and add.
    function automatic logic [12:0] row_times_per(input logic [4:0] row,
                                                  input logic odd);
        logic [12:0] r;
        r = {8'd0, row};
        if (odd) begin
            return (r << 5) + (r << 2);
        end else begin
            return (r << 6) + (r << 3);
        end
    endfunction

    assign busy = 1'b0;

    // Capture an item at every accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_operation <= i_operation;
            r_depth     <= i_depth_in;
            r_eta       <= i_eta_in;
            r_phi       <= i_phi_in;
            r_index     <= i_index_in;
        end
    end

    // Forward lookup: find the segment that holds depth and eta.
    always_comb begin
        fwd_hit = 1'b0;
        fwd_k   = 4'd0;
        for (int k = 0; k < calmap_pkg::NSEG; k++) begin
            if (calmap_pkg::SEGS[k].depth == r_depth &&
                r_eta >= calmap_pkg::SEGS[k].lo && r_eta <= calmap_pkg::SEGS[k].hi) begin
                fwd_hit = 1'b1;
                fwd_k   = 4'(k);
            end
        end
        seg_f  = calmap_pkg::SEGS[fwd_k];
        diff_f = r_eta - seg_f.lo;
        row_f  = diff_f[4:0];
        pm1_f  = r_phi - 7'd1;
        if (seg_f.odd_only) begin
            phi_ok_f = r_phi[0] && (r_phi <= 7'd71);
            pos_f    = {1'b0, pm1_f[6:1]};
        end else begin
            phi_ok_f = (r_phi >= 7'd1) && (r_phi <= 7'd72);
            pos_f    = pm1_f;
        end
        index_f = seg_f.base + row_times_per(row_f, seg_f.odd_only) + {6'd0, pos_f};
    end

    // Reverse lookup: find the segment whose index range holds the index,
    // then split the offset into row and position. The row is the offset
    // over 8 (or 4) divided by 9, done as a multiply by 57 and shift by 9,
    // exact for quotients below 512.
    always_comb begin
        rev_hit = 1'b0;
        rev_k   = 4'd0;
        for (int k = 0; k < calmap_pkg::NSEG; k++) begin
            if (r_index >= calmap_pkg::SEGS[k].base && r_index < calmap_pkg::SEGS[k].top) begin
                rev_hit = 1'b1;
                rev_k   = 4'(k);
            end
        end
        seg_r    = calmap_pkg::SEGS[rev_k];
        off_r    = r_index - seg_r.base;
        q_r      = seg_r.odd_only ? off_r[10:2] : {1'b0, off_r[10:3]};
        prod_r   = {6'd0, q_r} * 15'd57;
        row_r    = prod_r[13:9];
        rowper_r = row_times_per(row_r, seg_r.odd_only);
        pos_r    = 7'(off_r - rowper_r);
        phi_r    = seg_r.odd_only ? {pos_r[5:0], 1'b1} : (pos_r + 7'd1);
        eta_r    = seg_r.lo + $signed({1'b0, row_r});
    end

    // Select the result of the requested operation and classify it.
    always_comb begin
        n_index_out = calmap_pkg::INDEX_MISS;
        n_found     = 1'b0;
        n_depth_out = 2'd0;
        n_eta_out   = 6'sd0;
        n_phi_out   = 7'd0;
        case (r_operation)
            calmap_pkg::OP_TO_INDEX: begin
                if (fwd_hit && phi_ok_f) begin
                    n_index_out = index_f;
                    n_found     = 1'b1;
                    n_depth_out = r_depth;
                    n_eta_out   = r_eta;
                    n_phi_out   = r_phi;
                end
                n_class = calmap_pkg::classify(r_depth, r_eta);
            end
            calmap_pkg::OP_TO_CHANNEL: begin
                if (rev_hit) begin
                    n_index_out = r_index;
                    n_found     = 1'b1;
                    n_depth_out = seg_r.depth;
                    n_eta_out   = eta_r;
                    n_phi_out   = phi_r;
                end
                n_class = calmap_pkg::classify(n_depth_out, n_eta_out);
            end
            default: begin
                n_class = calmap_pkg::classify(2'd0, 6'sd0);
            end
        endcase
    end

    // Result register; the strobe marks one cycle per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
        if (r_in_valid) begin
            r_index_out <= n_index_out;
            r_found     <= n_found;
            r_depth_out <= n_depth_out;
            r_eta_out   <= n_eta_out;
            r_phi_out   <= n_phi_out;
            r_sub       <= n_class.sub;
            r_err       <= n_class.err;
        end
    end

    assign o_done        = r_done;
    assign o_index_out   = r_index_out;
    assign o_found       = r_found;
    assign o_depth_out   = r_depth_out;
    assign o_eta_out     = r_eta_out;
    assign o_phi_out     = r_phi_out;
    assign o_subdetector = r_sub;
    assign o_class_error = r_err;

    // Every accepted item gives its result through the input and result registers.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted item gave no result");

    // A hit carries an index inside the map and a real depth.
    a_found_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_index_out < calmap_pkg::INDEX_MISS &&
                                 o_depth_out != 2'd0))
        else $error("found result with bad index or depth");

    // A miss carries the miss index and a zero channel.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_index_out == calmap_pkg::INDEX_MISS &&
                                  o_depth_out == 2'd0 && o_phi_out == 7'd0))
        else $error("miss result not cleared");

    // A class error never comes with the endcap class.
    a_err_barrel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_class_error) |-> !o_subdetector)
        else $error("class error with endcap class");

endmodule
